FILE: design/hrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrm_pkg;

    localparam int MAX_EXPOSURES = 16;
    localparam int LEVELS        = 256;
    localparam int NUM_CH        = 3;
    localparam int TAYLOR_TERMS  = 13;

    // log2(e) and ln(2) in Q30
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // divider widths: rounded mean dividend and doubled weight total
    localparam int DIV_DW = 49;
    localparam int DIV_VW = 25;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        table_index;
        logic [1:0]        table_channel;
        logic signed [15:0] table_value;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic signed [15:0] log_exposure;
        logic              last_sample;
    } in_word_t;

    typedef struct packed {
        logic [31:0] radiance_red;
        logic [31:0] radiance_green;
        logic [31:0] radiance_blue;
        logic [2:0]  fallback_mask;
    } out_word_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       take_item;
        logic       rd_gz;
        logic       mul_w;
        logic       acc;
        logic       store;
        logic       rd_mid;
        logic       rd_edge;
        logic       set_fb;
        logic       div_mean;
        logic       set_mean;
        logic       exp_mul;
        logic       exp_red;
        logic       tay_mul;
        logic       div_tay;
        logic       tay_acc;
        logic       pack;
        logic       emit;
        logic [1:0] ch;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic last;
        logic full;
        logic total_zero;
        logic div_done;
        logic tay_last;
        logic out_free;
    } stat_t;

    // floor of v over the series index n
    function automatic longint unsigned div_term(input longint unsigned v, input int n);
        begin
            case (n)
                1:       return v;
                2:       return v >> 1;
                3:       return v / 64'd3;
                4:       return v >> 2;
                5:       return v / 64'd5;
                6:       return v / 64'd6;
                7:       return v / 64'd7;
                8:       return v >> 3;
                9:       return v / 64'd9;
                10:      return v / 64'd10;
                11:      return v / 64'd11;
                12:      return v / 64'd12;
                13:      return v / 64'd13;
                default: return v;
            endcase
        end
    endfunction

    // exponential helpers, evaluated at elaboration only
    function automatic longint exp_split(input longint x);
        longint y;
        longint unsigned u;
        begin
            y = x * 64'sd1549082005;
            u = longint'(y + (64'sd128 <<< 40));
            return longint'(u >> 40) - 64'sd128;
        end
    endfunction

    function automatic longint unsigned exp_sig(input longint x);
        longint y;
        longint unsigned u;
        longint unsigned f30;
        longint unsigned r;
        longint unsigned term;
        longint unsigned sum;
        begin
            y    = x * 64'sd1549082005;
            u    = longint'(y + (64'sd128 <<< 40));
            f30  = (u & ((64'd1 << 40) - 64'd1)) >> 10;
            r    = (f30 * 64'd744261118) >> 30;
            term = 64'd1 << 30;
            sum  = 64'd1 << 30;
            for (int n = 1; n <= 13; n++)
            begin
                term = div_term((term * r) >> 30, n);
                sum  = sum + term;
            end
            return sum;
        end
    endfunction

    // hat times gaussian weight, Q0.16
    function automatic logic [15:0] weight_of(input int z);
        longint hat;
        longint d;
        longint x;
        longint e;
        longint unsigned s;
        longint unsigned g;
        longint unsigned num;
        longint unsigned w;
        begin
            hat = ((z < 128) ? longint'(z) : longint'(255 - z)) - 64'sd10;
            if (hat <= 0)
                return 16'd0;
            d   = longint'(z) - 64'sd127;
            x   = -((d * d * 64'sd1024 + 64'sd312) / 64'sd625);
            e   = exp_split(x);
            s   = exp_sig(x);
            g   = (e >= 0) ? s : (s >> (-e));
            num = (g * longint'(hat)) << 16;
            // rounding by 117 * 2^29 over 117 * 2^30
            w   = (num + 64'd62813896704) / 64'd125627793408;
            return (w > 64'd65535) ? 16'hFFFF : w[15:0];
        end
    endfunction

    typedef logic [15:0] wtab_t [LEVELS];

    function automatic wtab_t build_wtab();
        wtab_t t;
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                t[i] = weight_of(i);
            end
            return t;
        end
    endfunction

    localparam wtab_t WEIGHT_TAB = build_wtab();

endpackage

`default_nettype wire

FILE: design/hrm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrm_in_if;
    logic              valid;
    logic              ready;
    hrm_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/hrm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrm_out_if;
    logic               valid;
    logic               ready;
    hrm_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/hrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/hrm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [hrm_pkg::DIV_DW-1:0] dividend,
    input  wire logic [hrm_pkg::DIV_VW-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic      [hrm_pkg::DIV_DW-1:0] quotient
);

    localparam int DW   = hrm_pkg::DIV_DW;
    localparam int VW   = hrm_pkg::DIV_VW;
    localparam int CNTW = $clog2(DW);

    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   dsr_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], ge};
            rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/hrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hrm_pkg::stat_t stat,
    output hrm_pkg::cmd_t       cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_MUL   = 5'd3;
    localparam logic [4:0] S_ACC   = 5'd4;
    localparam logic [4:0] S_FCHK  = 5'd5;
    localparam logic [4:0] S_MID   = 5'd6;
    localparam logic [4:0] S_FB    = 5'd7;
    localparam logic [4:0] S_DIV   = 5'd8;
    localparam logic [4:0] S_EXP0  = 5'd9;
    localparam logic [4:0] S_EXP1  = 5'd10;
    localparam logic [4:0] S_TMUL  = 5'd11;
    localparam logic [4:0] S_TDIV  = 5'd12;
    localparam logic [4:0] S_TWAIT = 5'd13;
    localparam logic [4:0] S_PACK  = 5'd14;
    localparam logic [4:0] S_EMIT  = 5'd15;

    localparam logic [1:0] CH_LAST = 2'(hrm_pkg::NUM_CH - 1);

    logic [4:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                ch_next = 2'd0;
                if (stat.is_load)
                    state_next = S_IDLE;
                else if (!stat.full)
                    state_next = S_RD;
                else if (stat.last)
                    state_next = S_FCHK;
                else
                    state_next = S_IDLE;
            end
            S_RD:
            begin
                cmd.rd_gz  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_w  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    cmd.store  = 1'b1;
                    ch_next    = 2'd0;
                    state_next = stat.last ? S_FCHK : S_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_FCHK:
            begin
                if (stat.total_zero)
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_MID;
                end
                else
                begin
                    cmd.div_mean = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_MID:
            begin
                cmd.rd_edge = 1'b1;
                state_next  = S_FB;
            end
            S_FB:
            begin
                cmd.set_fb = 1'b1;
                state_next = S_EXP0;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.set_mean = 1'b1;
                    state_next   = S_EXP0;
                end
            end
            S_EXP0:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = S_EXP1;
            end
            S_EXP1:
            begin
                cmd.exp_red = 1'b1;
                state_next  = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.tay_mul = 1'b1;
                state_next  = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_tay = 1'b1;
                state_next  = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.tay_acc = 1'b1;
                    state_next  = stat.tay_last ? S_PACK : S_TMUL;
                end
            end
            S_PACK:
            begin
                cmd.pack = 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_FCHK;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/hrm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hrm_dp #(
    parameter int MAX_EXPOSURES = hrm_pkg::MAX_EXPOSURES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hrm_pkg::in_word_t in_word,
    input  wire hrm_pkg::cmd_t     cmd,
    output hrm_pkg::stat_t         stat,
    output logic                   out_valid,
    output hrm_pkg::out_word_t     out_word,
    input  wire logic              out_ready
);

    localparam int CW   = $clog2(MAX_EXPOSURES + 1);
    localparam int AW   = $clog2(MAX_EXPOSURES);
    localparam int RAW  = $clog2(3 * hrm_pkg::LEVELS);
    localparam int DW   = hrm_pkg::DIV_DW;
    localparam int VW   = hrm_pkg::DIV_VW;

    hrm_pkg::in_word_t  item_reg;
    hrm_pkg::out_word_t out_reg;
    logic               out_valid_reg;

    logic signed [33:0] prod_reg;
    logic signed [47:0] wsum_reg [hrm_pkg::NUM_CH];
    logic [23:0]        wtot_reg [hrm_pkg::NUM_CH];
    logic [CW-1:0]      count_reg;
    logic signed [15:0] short_reg;
    logic               zflag_reg;
    logic signed [17:0] lr_reg;
    logic [2:0]         mask_reg;
    logic signed [9:0]  e_reg;
    logic [29:0]        f30_reg;
    logic [29:0]        r_reg;
    logic [30:0]        term_reg;
    logic [31:0]        sum_reg;
    logic [3:0]         n_reg;
    logic [30:0]        p_reg;
    logic [31:0]        res_reg [hrm_pkg::NUM_CH];

    // response table and sample store
    logic               g_we;
    logic [RAW-1:0]     g_waddr;
    logic [RAW-1:0]     g_raddr;
    logic [15:0]        g_rdata;
    logic [CW-1:0]      mid_idx;
    logic [23:0]        s_rdata;

    logic [7:0]         cur_byte;
    logic [7:0]         mid_byte;
    logic               mid_zero;
    logic [15:0]        cur_w;
    logic signed [17:0] g_minus_t;
    logic signed [34:0] wprod;
    logic [47:0]        mag;
    logic [DW-1:0]      div_dvd;
    logic [VW-1:0]      div_dsr;
    logic [DW-1:0]      div_q;
    logic               div_busy;
    logic               div_done;
    logic signed [49:0] yprod;
    logic [59:0]        rprod;
    logic [60:0]        tprod;
    logic [32:0]        mround;
    logic [25:0]        mfull;
    logic [22:0]        mant;
    logic signed [9:0]  e_adj;
    logic signed [9:0]  e_bias;
    logic signed [17:0] fb_lr;

    assign g_we    = cmd.take_item && (in_word.cmd == hrm_pkg::CMD_LOAD)
                     && (in_word.table_channel != 2'd3);
    assign g_waddr = RAW'({in_word.table_channel, in_word.table_index});

    // byte of the current channel, from the item and from the middle stored sample
    always_comb
    begin
        case (cmd.ch)
            2'd0:    cur_byte = item_reg.red;
            2'd1:    cur_byte = item_reg.green;
            default: cur_byte = item_reg.blue;
        endcase
        case (cmd.ch)
            2'd0:    mid_byte = s_rdata[7:0];
            2'd1:    mid_byte = s_rdata[15:8];
            default: mid_byte = s_rdata[23:16];
        endcase
    end

    assign mid_zero = (mid_byte == 8'd0);
    assign g_raddr  = cmd.rd_edge ? RAW'({cmd.ch, mid_zero ? 8'h00 : 8'hFF})
                                  : RAW'({cmd.ch, cur_byte});
    assign mid_idx  = count_reg >> 1;

    hrm_ram #(
        .WIDTH (16),
        .DEPTH (3 * hrm_pkg::LEVELS)
    ) u_resp_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (in_word.table_value),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    hrm_ram #(
        .WIDTH (24),
        .DEPTH (MAX_EXPOSURES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (count_reg[AW-1:0]),
        .wdata ({item_reg.blue, item_reg.green, item_reg.red}),
        .raddr (mid_idx[AW-1:0]),
        .rdata (s_rdata)
    );

    // weighted sample term
    assign cur_w     = hrm_pkg::WEIGHT_TAB[cur_byte];
    assign g_minus_t = 18'(signed'(g_rdata)) - 18'(item_reg.log_exposure);
    assign wprod     = $signed({1'b0, cur_w}) * g_minus_t;

    // fallback log radiance
    assign fb_lr = 18'(signed'(g_rdata))
                   - (zflag_reg ? 18'(item_reg.log_exposure) : 18'(short_reg));

    // shared divider: rounded mean or taylor step
    assign mag = wsum_reg[cmd.ch][47] ? (48'd0 - wsum_reg[cmd.ch]) : wsum_reg[cmd.ch];
    always_comb
    begin
        if (cmd.div_mean)
        begin
            div_dvd = {mag, 1'b0} + DW'(wtot_reg[cmd.ch]);
            div_dsr = {wtot_reg[cmd.ch], 1'b0};
        end
        else
        begin
            div_dvd = DW'(p_reg);
            div_dsr = VW'(n_reg);
        end
    end

    hrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_mean || cmd.div_tay),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // exponential and float packing
    assign yprod  = lr_reg * $signed({1'b0, hrm_pkg::LOG2E_Q30});
    assign rprod  = f30_reg * hrm_pkg::LN2_Q30;
    assign tprod  = term_reg * r_reg;
    assign mround = {1'b0, sum_reg} + 33'd64;
    assign mfull  = mround[32:7];
    assign mant   = mfull[24] ? mfull[23:1] : mfull[22:0];
    assign e_adj  = e_reg + (mfull[24] ? 10'sd1 : 10'sd0);
    assign e_bias = e_adj + 10'sd127;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            short_reg     <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < hrm_pkg::NUM_CH; i++)
            begin
                wsum_reg[i] <= '0;
                wtot_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !cmd.emit)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.acc)
            begin
                wsum_reg[cmd.ch] <= wsum_reg[cmd.ch] + 48'(prod_reg);
                wtot_reg[cmd.ch] <= wtot_reg[cmd.ch] + 24'(cur_w);
            end
            if (cmd.store)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    short_reg <= item_reg.log_exposure;
                end
            end
            if (cmd.set_fb)
            begin
                mask_reg[cmd.ch] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                short_reg     <= '0;
                mask_reg      <= '0;
                for (int i = 0; i < hrm_pkg::NUM_CH; i++)
                begin
                    wsum_reg[i] <= '0;
                    wtot_reg[i] <= '0;
                end
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            item_reg <= in_word;
        if (cmd.mul_w)
            prod_reg <= wprod[33:0];
        if (cmd.rd_edge)
            zflag_reg <= mid_zero;
        if (cmd.set_fb)
            lr_reg <= fb_lr;
        if (cmd.set_mean)
            lr_reg <= wsum_reg[cmd.ch][47] ? (18'sd0 - signed'(div_q[17:0]))
                                           : signed'(div_q[17:0]);
        if (cmd.exp_mul)
        begin
            e_reg   <= yprod[49:40];
            f30_reg <= yprod[39:10];
        end
        if (cmd.exp_red)
        begin
            r_reg    <= rprod[59:30];
            term_reg <= 31'd1 << 30;
            sum_reg  <= 32'd1 << 30;
            n_reg    <= 4'd1;
        end
        if (cmd.tay_mul)
            p_reg <= tprod[60:30];
        if (cmd.tay_acc)
        begin
            term_reg <= div_q[30:0];
            sum_reg  <= sum_reg + {1'b0, div_q[30:0]};
            n_reg    <= n_reg + 4'd1;
        end
        if (cmd.pack)
            res_reg[cmd.ch] <= {1'b0, e_bias[7:0], mant};
        if (cmd.emit)
        begin
            out_reg.radiance_red   <= res_reg[0];
            out_reg.radiance_green <= res_reg[1];
            out_reg.radiance_blue  <= res_reg[2];
            out_reg.fallback_mask  <= mask_reg;
        end
    end

    always_comb
    begin
        stat.is_load    = (item_reg.cmd == hrm_pkg::CMD_LOAD);
        stat.last       = item_reg.last_sample;
        stat.full       = (count_reg >= CW'(MAX_EXPOSURES));
        stat.total_zero = (wtot_reg[cmd.ch] == 24'd0);
        stat.div_done   = div_done;
        stat.tay_last   = (n_reg == 4'(hrm_pkg::TAYLOR_TERMS));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EXPOSURES))
        else $error("sample count beyond store depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites an untaken word");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_mean || cmd.div_tay) |-> !div_busy)
        else $error("divider started while busy");

    a_pixel_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (count_reg == '0 && mask_reg == 3'd0 && out_valid_reg))
        else $error("pixel state not cleared after result");

    a_store_guard: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (count_reg < CW'(MAX_EXPOSURES)))
        else $error("sample stored into a full store");
`endif

endmodule

`default_nettype wire

FILE: design/hdr_radiance_merge_top.sv
// HDR radiance merge of one pixel from several exposures.
// Input channel "items" carries one word per handshake. A load word (cmd 0)
// writes one entry of the 3 x 256 log-response table in the cycle it is taken;
// a table_channel of 3 is ignored. A sample word (cmd 1) carries the RGB bytes
// and ln(exposure time), shortest exposure first; up to MAX_EXPOSURES samples per
// pixel are merged, later ones are dropped, and the word marked last_sample closes the pixel.
// Output channel "results" carries one word per pixel: three IEEE singles and
// a per-channel mask that flags the zero-weight fallback.
// Steps: a load or a dropped non-final sample returns to idle from dispatch; a
// kept sample is merged by three lookups on one shared multiplier. The final sample
// adds per channel the rounded mean on the 49-bit serial divider (skipped for a
// fallback), then the exponential, whose thirteen series terms each use that same
// divider. One pixel is processed at a time; items.ready is high only when idle.
// Reset clears the accumulators, the sample count and the output valid; the
// response table keeps no reset and must be loaded before use.
// A stalled receiver holds the result in the output register; the block goes
// on taking loads and samples of the next pixel until it must emit again.
`timescale 1ns / 1ps
`default_nettype none

module hdr_radiance_merge_top #(
    parameter int MAX_EXPOSURES = hrm_pkg::MAX_EXPOSURES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hrm_in_if.sink     items,
    hrm_out_if.source  results
);

    hrm_pkg::cmd_t  cmd;
    hrm_pkg::stat_t stat;

    hrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hrm_dp #(
        .MAX_EXPOSURES (MAX_EXPOSURES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (items.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (results.valid),
        .out_word  (results.data),
        .out_ready (results.ready)
    );

endmodule

`default_nettype wire

FILE: sim/tb_hdr_radiance_merge_top.sv
`timescale 1ns / 1ps

module tb_hdr_radiance_merge_top;
    import hrm_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 3000;

    logic clk;
    logic rst_n;

    hrm_in_if  items_if ();
    hrm_out_if results_if ();

    hdr_radiance_merge_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // idling knobs of sender and receiver
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned recv_hold_cycles;
    bit          failed;
    int unsigned cycle_cnt;

    // predictor state
    bit [15:0]       resp_lut [3*LEVELS];
    bit              lut_set [3*LEVELS];
    longint          wsum [3];
    int unsigned     wtot [3];
    bit [23:0]       held_px [MAX_EXPOSURES];
    int unsigned     held_n;
    int              first_lnt;
    bit [15:0]       hat_gauss [LEVELS];
    out_word_t       radiance_q [$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // exponential split into exponent and Q30 significand
    function automatic void exp_parts(input int x, output int e, output longint unsigned s);
        longint            y;
        longint unsigned   u;
        longint unsigned   f30;
        longint unsigned   r;
        longint unsigned   term;
        begin
            y    = longint'(x) * 64'sd1549082005;
            u    = longint'(y + (64'sd128 <<< 40));
            f30  = (u & ((64'd1 << 40) - 64'd1)) >> 10;
            r    = (f30 * 64'd744261118) >> 30;
            term = 64'd1 << 30;
            s    = 64'd1 << 30;
            for (int n = 1; n <= 13; n++)
            begin
                term = ((term * r) >> 30) / longint'(n);
                s    = s + term;
            end
            e = int'(u >> 40) - 128;
        end
    endfunction

    function automatic bit [31:0] radiance_bits(input int lr_q10);
        int              e;
        longint unsigned s;
        longint unsigned m;
        begin
            exp_parts(lr_q10, e, s);
            m = (s + 64) >> 7;
            if (m >= (64'd1 << 24))
            begin
                m = m >> 1;
                e = e + 1;
            end
            return {9'(e + 127), 23'(m)};
        end
    endfunction

    function automatic bit [15:0] level_weight(input int z);
        int              hat;
        int              d;
        int              x;
        int              e;
        longint unsigned s;
        longint unsigned g;
        longint unsigned w;
        begin
            hat = ((z < 128) ? z : 255 - z) - 10;
            if (hat <= 0)
                return 16'd0;
            d = z - 127;
            x = -int'((longint'(d * d) * 1024 + 312) / 625);
            exp_parts(x, e, s);
            g = (e >= 0) ? s : (s >> (-e));
            w = (((g * longint'(hat)) << 16) + (64'd117 << 29)) / (64'd117 << 30);
            return (w > 65535) ? 16'hFFFF : w[15:0];
        end
    endfunction

    function automatic void clear_pixel();
        begin
            for (int c = 0; c < 3; c++)
            begin
                wsum[c] = 0;
                wtot[c] = 0;
            end
            held_n    = 0;
            first_lnt = 0;
        end
    endfunction

    // fold one accepted word into the predicted pixel state
    function automatic void merge_word(input in_word_t w);
        int         lnt;
        bit [7:0]   px [3];
        int         gz;
        int         lr;
        bit [23:0]  mid;
        bit [7:0]   z;
        longint unsigned mag;
        longint unsigned q;
        out_word_t  res;
        begin
            lnt = w.log_exposure;
            if (w.cmd == CMD_LOAD)
            begin
                if (w.table_channel != 2'd3)
                begin
                    resp_lut[w.table_channel * LEVELS + w.table_index] = w.table_value;
                    lut_set[w.table_channel * LEVELS + w.table_index]  = 1'b1;
                end
                return;
            end
            px[0] = w.red;
            px[1] = w.green;
            px[2] = w.blue;
            if (held_n < MAX_EXPOSURES)
            begin
                if (held_n == 0)
                    first_lnt = lnt;
                for (int c = 0; c < 3; c++)
                begin
                    gz = $signed(resp_lut[c * LEVELS + px[c]]);
                    wsum[c] += longint'(hat_gauss[px[c]]) * longint'(gz - lnt);
                    wtot[c] += hat_gauss[px[c]];
                end
                held_px[held_n] = {px[2], px[1], px[0]};
                held_n++;
            end
            if (!w.last_sample)
                return;
            res.fallback_mask = '0;
            for (int c = 0; c < 3; c++)
            begin
                if (wtot[c] == 0)
                begin
                    mid = held_px[(held_n / 2) % MAX_EXPOSURES];
                    z   = mid[8*c +: 8];
                    if (z == 0)
                        lr = $signed(resp_lut[c * LEVELS]) - lnt;
                    else
                        lr = $signed(resp_lut[c * LEVELS + LEVELS - 1]) - first_lnt;
                    res.fallback_mask[c] = 1'b1;
                end
                else
                begin
                    mag = (wsum[c] < 0) ? -wsum[c] : wsum[c];
                    q   = (2 * mag + wtot[c]) / (2 * longint'(wtot[c]));
                    lr  = (wsum[c] < 0) ? -int'(q) : int'(q);
                end
                case (c)
                    0: res.radiance_red   = radiance_bits(lr);
                    1: res.radiance_green = radiance_bits(lr);
                    default: res.radiance_blue = radiance_bits(lr);
                endcase
            end
            radiance_q.push_back(res);
            clear_pixel();
        end
    endfunction

    // receiver: random stall, long hold-off, result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (recv_hold_cycles > 0)
            begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
            if (results_if.valid && results_if.ready)
            begin
                if (radiance_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    out_word_t exp_w;
                    exp_w = radiance_q.pop_front();
                    if (results_if.data.radiance_red !== exp_w.radiance_red)
                    begin
                        $error("radiance_red exp %h got %h", exp_w.radiance_red,
                               results_if.data.radiance_red);
                        failed = 1'b1;
                    end
                    if (results_if.data.radiance_green !== exp_w.radiance_green)
                    begin
                        $error("radiance_green exp %h got %h", exp_w.radiance_green,
                               results_if.data.radiance_green);
                        failed = 1'b1;
                    end
                    if (results_if.data.radiance_blue !== exp_w.radiance_blue)
                    begin
                        $error("radiance_blue exp %h got %h", exp_w.radiance_blue,
                               results_if.data.radiance_blue);
                        failed = 1'b1;
                    end
                    if (results_if.data.fallback_mask !== exp_w.fallback_mask)
                    begin
                        $error("fallback_mask exp %b got %b", exp_w.fallback_mask,
                               results_if.data.fallback_mask);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // send one word; valid stays high until the next idle gap
    task automatic send_word(input in_word_t w);
        begin
            if ($urandom_range(99) < send_idle_pct)
            begin
                items_if.valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < send_idle_pct)
                    @(posedge clk);
            end
            items_if.valid <= 1'b1;
            items_if.data  <= w;
            do
                @(posedge clk);
            while (!items_if.ready);
            merge_word(w);
        end
    endtask

    task automatic send_load(input int idx, input int ch, input int val);
        in_word_t w;
        begin
            w               = in_word_t'({$urandom, $urandom, $urandom});
            w.cmd           = CMD_LOAD;
            w.table_index   = idx;
            w.table_channel = ch;
            w.table_value   = val;
            send_word(w);
        end
    endtask

    task automatic send_sample(input int r, input int g, input int b, input int lnt,
                               input bit last);
        in_word_t w;
        begin
            w              = in_word_t'({$urandom, $urandom, $urandom});
            w.cmd          = CMD_SAMPLE;
            w.red          = r;
            w.green        = g;
            w.blue         = b;
            w.log_exposure = lnt;
            w.last_sample  = last;
            send_word(w);
        end
    endtask

    // every 4th level and the top, rising log curve plus noise; extremes, ch 3
    task automatic test_table_fill();
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < LEVELS; i += 4)
                    send_load(i, c, (i - 128) * 40 + $urandom_range(63) - 32);
                send_load(LEVELS - 1, c, (LEVELS - 1 - 128) * 40 + $urandom_range(63) - 32);
            end
            send_load(0, 0, -32768);
            send_load(255, 2, 32767);
            send_load(17, 3, 12345);
        end
    endtask

    // extremes, both fallback branches, loads inside a pixel
    task automatic test_directed();
        begin
            send_sample(128, 128, 128, 0, 1'b1);
            send_sample(0, 255, 0, -32768, 1'b1);
            send_sample(255, 0, 255, 32767, 1'b1);
            send_sample(4, 252, 0, -2000, 1'b0);
            send_load(200, 1, 1500);
            send_sample(0, 128, 255, 0, 1'b0);
            send_sample(252, 4, 60, 2000, 1'b1);
            send_sample(12, 244, 100, -1024, 1'b0);
            send_sample(12, 244, 200, 1024, 1'b1);
            send_sample(0, 0, 0, 100, 1'b0);
            send_sample(255, 255, 255, 300, 1'b1);
        end
    endtask

    function automatic int pick_level(input int c, input bit dark);
        int z;
        begin
            do
            begin
                if (dark)
                    z = ($urandom_range(1)) ? $urandom_range(10) : 245 + $urandom_range(10);
                else
                    z = $urandom_range(255);
            end
            while (!lut_set[c * LEVELS + z]);
            return z;
        end
    endfunction

    // more samples than the store holds, the last two dropped
    task automatic test_excess_samples();
        begin
            for (int i = 0; i < MAX_EXPOSURES + 2; i++)
                send_sample(pick_level(0, 1'b0), (i < 9) ? 0 : 255, 252, i * 300 - 3000,
                            i == MAX_EXPOSURES + 1);
        end
    endtask

    // random pixels with random loads mixed in
    task automatic run_pixels(input int n_words);
        int  sent;
        int  n_exp;
        int  lnt;
        bit  dark;
        begin
            sent = 0;
            while (sent < n_words)
            begin
                n_exp = ($urandom_range(19) == 0) ? MAX_EXPOSURES + $urandom_range(3)
                                                  : 1 + $urandom_range(5);
                dark  = ($urandom_range(4) == 0);
                lnt   = $urandom_range(8000) - 6000;
                for (int i = 0; i < n_exp; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_load($urandom_range(255), $urandom_range(3), $urandom);
                        sent++;
                    end
                    if ($urandom_range(15) == 0)
                        lnt = $urandom;
                    send_sample(pick_level(0, dark), pick_level(1, dark), pick_level(2, dark),
                                lnt, i == n_exp - 1);
                    lnt += $urandom_range(1500);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_idling();
        begin
            send_idle_pct = 0;  recv_stall_pct = 0;  run_pixels(60);
            send_idle_pct = 80; recv_stall_pct = 0;  run_pixels(60);
            send_idle_pct = 0;  recv_stall_pct = 80; run_pixels(60);
            send_idle_pct = 31; recv_stall_pct = 31; run_pixels(60);
        end
    endtask

    // receiver holds off long while pixels keep coming
    task automatic test_backpressure();
        begin
            send_idle_pct    = 0;
            recv_stall_pct   = 0;
            recv_hold_cycles = 8000;
            run_pixels(30);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        failed           = 1'b0;
        cycle_cnt        = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        items_if.valid   = 1'b0;
        items_if.data    = '0;
        for (int i = 0; i < LEVELS; i++)
            hat_gauss[i] = level_weight(i);
        for (int i = 0; i < 3 * LEVELS; i++)
        begin
            resp_lut[i] = '0;
            lut_set[i]  = 1'b0;
        end
        clear_pixel();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_directed();
        test_excess_samples();
        test_random_idling();
        test_backpressure();

        items_if.valid <= 1'b0;
        while (radiance_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
